[sv/tsht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsht_pkg
// Shared types and constants of the topmost shape hit test block.
// ----------------------------------------------------------------------------
package tsht_pkg;

	localparam int TABLE_SLOTS_DEF = 64;
	localparam int COORD_W         = 16;
	localparam int RSQ_W           = 32;
	localparam int SLOT_W          = 6;
	localparam int COUNT_W         = 7;
	localparam int DIFF_W          = COORD_W + 1;
	localparam int DSQ_W           = 2 * COORD_W;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef enum logic {
		KIND_RECT   = 1'b0,
		KIND_CIRCLE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	// One table entry as stored in the element RAM
	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] bottom;
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [RSQ_W-1:0]   rsq;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic query_init;
		logic issue;
		logic flush;
		logic report_hit;
		logic report_miss;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic n_zero;
		logic last_issue;
		logic hit;
		logic pipe_empty;
	} status_t;

endpackage

[sv/tsht_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/tsht_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsht_ctrl
// Request controller: takes load and query requests, runs the top-down scan
// and decides when the result goes out.
// ----------------------------------------------------------------------------
module tsht_ctrl
	import tsht_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    action,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (action == ACT_QUERY) begin
						cmd.query_init = 1'b1;
						if (status.n_zero) begin
							cmd.report_miss = 1'b1;
						end else begin
							state_d = ST_SCAN;
						end
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				// A hit from the pipe ends the scan: it is the highest slot
				if (status.hit) begin
					cmd.report_hit = 1'b1;
					cmd.flush      = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					cmd.issue = 1'b1;
					if (status.last_issue) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				priority if (status.hit) begin
					cmd.report_hit = 1'b1;
					cmd.flush      = 1'b1;
					state_d        = ST_IDLE;
				end else if (status.pipe_empty) begin
					cmd.report_miss = 1'b1;
					state_d         = ST_IDLE;
				end else begin
					// Hold until the last slot read leaves the pipe
					state_d = ST_DRAIN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Assertions
	a_drain_no_issue: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> !cmd.issue)
		else $error("slot read issued while draining");

	a_report_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.report_hit || cmd.report_miss) |=> state_q == ST_IDLE)
		else $error("controller not idle after reporting");

	a_single_report: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.report_hit && cmd.report_miss))
		else $error("hit and miss reported together");

endmodule

[sv/tsht_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsht_dp
// Datapath: element RAM, live count register, scan counter and the
// three-stage containment pipeline, plus the result register.
// ----------------------------------------------------------------------------
module tsht_dp
	import tsht_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output status_t                   status,
	input  logic [SLOT_W-1:0]         slot,
	input  entry_t                    wr_entry,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic                      cfg_we,
	input  logic [COUNT_W-1:0]        cfg_wdata,
	output logic                      done,
	output logic                      hit_found,
	output logic [SLOT_W-1:0]         hit_slot
);

	localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CW = $clog2(TABLE_SLOTS + 1);

	logic [COUNT_W-1:0] live_count_q;
	logic [COORD_W-1:0] px_q;
	logic [COORD_W-1:0] py_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_dec;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic [31:0]        slot_ext;
	logic [31:0]        live_ext;
	logic [31:0]        n_ext;
	logic               ram_we;
	logic [$bits(entry_t)-1:0] rdata;
	entry_t             e_s1;

	logic               v_s1;
	logic [AW-1:0]      idx_s1;

	logic               v_s2;
	logic [AW-1:0]      idx_s2;
	logic               box_ok_s2;
	logic               kind_s2;
	logic [RSQ_W-1:0]   rsq_s2;
	logic signed [DIFF_W-1:0] dx_s2;
	logic signed [DIFF_W-1:0] dy_s2;

	logic               v_s3;
	logic [AW-1:0]      idx_s3;
	logic               box_ok_s3;
	logic               kind_s3;
	logic [RSQ_W-1:0]   rsq_s3;
	logic [DSQ_W-1:0]   dxx_s3;
	logic [DSQ_W-1:0]   dyy_s3;

	logic signed [2*DIFF_W-1:0] dxx_full;
	logic signed [2*DIFF_W-1:0] dyy_full;
	logic [DSQ_W:0]     d2;
	logic               box_ok;
	logic               hit_s3;
	logic [31:0]        idx_ext;

	logic               done_q;
	logic               hit_found_q;
	logic [SLOT_W-1:0]  hit_slot_q;

	// Live count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_count_q <= '0;
		end else if (cfg_we) begin
			live_count_q <= cfg_wdata;
		end
	end

	// Clamp the live count to the slots that exist
	assign live_ext = 32'(live_count_q);
	assign n_ext    = (live_ext > 32'(TABLE_SLOTS)) ? 32'(TABLE_SLOTS) : live_ext;

	// Load path: drop writes beyond the table
	assign slot_ext = 32'(slot);
	assign waddr    = slot_ext[AW-1:0];
	assign ram_we   = cmd.load && (slot_ext < 32'(TABLE_SLOTS));

	// Scan counter: holds the number of slots still to read
	assign cnt_dec = cnt_q - CW'(1);
	assign raddr   = cnt_dec[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.query_init) begin
			cnt_q <= n_ext[CW-1:0];
		end else if (cmd.issue) begin
			cnt_q <= cnt_dec;
		end
	end

	// Hold the query point
	always_ff @(posedge clk) begin
		if (cmd.query_init) begin
			px_q <= point_x;
			py_q <= point_y;
		end
	end

	tsht_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr),
		.wdata (wr_entry),
		.re    (cmd.issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign e_s1 = entry_t'(rdata);

	// Valid bits of the pipeline; flush drops everything in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (cmd.flush) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1 to 2: box test and centre offsets
	assign box_ok = ($signed(px_q) >= $signed(e_s1.left))
		&& ($signed(px_q) <= $signed(e_s1.right))
		&& ($signed(py_q) >= $signed(e_s1.top))
		&& ($signed(py_q) <= $signed(e_s1.bottom));

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			idx_s1 <= raddr;
		end
		idx_s2    <= idx_s1;
		box_ok_s2 <= box_ok;
		kind_s2   <= e_s1.kind;
		rsq_s2    <= e_s1.rsq;
		dx_s2     <= $signed({px_q[COORD_W-1], px_q})
			- $signed({e_s1.cx[COORD_W-1], e_s1.cx});
		dy_s2     <= $signed({py_q[COORD_W-1], py_q})
			- $signed({e_s1.cy[COORD_W-1], e_s1.cy});
	end

	// Stage 2 to 3: squares; each fits in DSQ_W bits unsigned
	assign dxx_full = dx_s2 * dx_s2;
	assign dyy_full = dy_s2 * dy_s2;

	always_ff @(posedge clk) begin
		idx_s3    <= idx_s2;
		box_ok_s3 <= box_ok_s2;
		kind_s3   <= kind_s2;
		rsq_s3    <= rsq_s2;
		dxx_s3    <= dxx_full[DSQ_W-1:0];
		dyy_s3    <= dyy_full[DSQ_W-1:0];
	end

	// Stage 3: distance compare for circles
	assign d2     = {1'b0, dxx_s3} + {1'b0, dyy_s3};
	assign hit_s3 = v_s3 && box_ok_s3
		&& ((kind_s3 != KIND_CIRCLE) || (d2 <= (DSQ_W + 1)'(rsq_s3)));

	assign status.n_zero     = (live_count_q == '0);
	assign status.last_issue = (cnt_q == CW'(1));
	assign status.hit        = hit_s3;
	assign status.pipe_empty = !v_s1 && !v_s2 && !v_s3;

	// Result register: strobe for one cycle
	assign idx_ext = 32'(idx_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.report_hit || cmd.report_miss;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.report_hit) begin
			hit_found_q <= 1'b1;
			hit_slot_q  <= idx_ext[SLOT_W-1:0];
		end else if (cmd.report_miss) begin
			hit_found_q <= 1'b0;
			hit_slot_q  <= '0;
		end
	end

	assign done      = done_q;
	assign hit_found = hit_found_q;
	assign hit_slot  = hit_slot_q;

	// Assertions
	a_issue_counted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> cnt_q != '0)
		else $error("slot read issued with no slots left");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (!v_s1 && !v_s2 && !v_s3))
		else $error("pipeline not empty after flush");

	a_miss_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !hit_found_q) |-> hit_slot_q == '0)
		else $error("miss reported with nonzero slot");

endmodule

[sv/topmost_shape_hit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topmost_shape_hit_test
// Table of screen elements with a topmost point hit test.
// ----------------------------------------------------------------------------
// A load request (action 0) writes one slot of the element table; busy stays
// low and no result follows. A query request (action 1) scans its live slots,
// min(live_count, TABLE_SLOTS) of them, from the top down, one slot per cycle
// through the single read port of the element RAM, with three pipeline stages
// behind the read. The result strobe done rises after the last slot read
// leaves the pipe, or sooner when a hit ends the scan; a zero live count
// answers on the next cycle. Busy is high while a query is in work. The result
// is on hit_found and hit_slot for the single cycle that done is high and
// cannot be held off, so the receiver must take it then. The user must see
// that live_count is written through cfg_we and cfg_wdata only while the block
// is idle; the block itself does not enforce this.
module topmost_shape_hit_test
	import tsht_pkg::*;
#(
	parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic                      action,
	input  logic [SLOT_W-1:0]         slot,
	input  logic                      shape_kind,
	input  logic signed [COORD_W-1:0] box_left,
	input  logic signed [COORD_W-1:0] box_right,
	input  logic signed [COORD_W-1:0] box_top,
	input  logic signed [COORD_W-1:0] box_bottom,
	input  logic signed [COORD_W-1:0] center_x,
	input  logic signed [COORD_W-1:0] center_y,
	input  logic [RSQ_W-1:0]          radius_sq,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic                      cfg_we,
	input  logic [COUNT_W-1:0]        cfg_wdata,
	output logic                      done,
	output logic                      hit_found,
	output logic [SLOT_W-1:0]         hit_slot
);

	cmd_t    cmd;
	status_t status;
	entry_t  wr_entry;

	// Pack the load request into one table entry
	assign wr_entry = '{
		kind:   shape_kind,
		left:   box_left,
		right:  box_right,
		top:    box_top,
		bottom: box_bottom,
		cx:     center_x,
		cy:     center_y,
		rsq:    radius_sq
	};

	tsht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	tsht_dp #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.slot      (slot),
		.wr_entry  (wr_entry),
		.point_x   (point_x),
		.point_y   (point_y),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.hit_found (hit_found),
		.hit_slot  (hit_slot)
	);

endmodule
